// ===== rtl/ncc_pkg.sv =====
// Shared types and character codes for the copula canonicalizer.
`timescale 1ns / 1ps

package ncc_pkg;

    localparam int MAX_LEN = 256;
    // Length counter saturates at MAX_LEN + 1.
    localparam int LEN_W   = $clog2(MAX_LEN + 2);
    localparam int MAX_TOK = 5;
    localparam int TOK_W   = $clog2(MAX_TOK + 1);
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_LBRK   = "[";
    localparam logic [7:0] CH_RBRK   = "]";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_LT     = "<";
    localparam logic [7:0] CH_GT     = ">";
    localparam logic [7:0] CH_AMP    = "&";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_BSLASH = "\\";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_EQ     = "=";
    localparam logic [7:0] CH_BAR    = "|";
    localparam logic [7:0] CH_ONE    = "1";
    localparam logic [7:0] CH_TWO    = "2";
    localparam logic [7:0] CH_COLON  = ":";
    localparam logic [7:0] CH_DOLLAR = "$";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_PCT    = "%";
    localparam logic [7:0] CH_HASH   = "#";
    localparam logic [7:0] CH_BANG   = "!";
    localparam logic [7:0] CH_LPAR   = "(";
    localparam logic [7:0] CH_RPAR   = ")";
    localparam logic [7:0] CH_QUOTE  = "'";
    localparam logic [7:0] CH_DQUOTE = "\"";

    // Canonical characters produced by one input byte, before paren padding.
    typedef struct packed {
        logic [MAX_TOK-1:0][7:0] tok;
        logic [TOK_W-1:0]        ntok;
        logic                    fin;
        logic                    tl;
    } t_rec;

endpackage

// ===== rtl/ncc_front.sv =====
// Front end: lookahead buffer, copula matching and length tracking.
`timescale 1ns / 1ps

module ncc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_char_in,
    input  logic          i_final_char,
    input  logic          i_full,
    output logic          o_accept,
    output logic          o_push,
    output ncc_pkg::t_rec o_rec
);
    import ncc_pkg::*;

    typedef struct packed {
        logic [MAX_TOK-1:0][7:0] tok;
        logic [TOK_W-1:0]        ntok;
        logic [1:0][7:0]         rest;
        logic [1:0]              rcnt;
    } t_dec;

    function automatic t_dec decode(input logic [2:0][7:0] wi, input logic [1:0] ci,
                                    input logic fin);
        t_dec            d;
        logic [2:0][7:0] w;
        logic [1:0]      c;
        logic            stop;
        logic [7:0]      b0;
        logic [7:0]      b1;
        logic [7:0]      r;
        logic [2:0][7:0] g;
        logic [1:0]      gn;
        logic [1:0]      take;
        logic            wt;
        logic            plain;
        logic            triple;
        logic [TOK_W-1:0] n;
        d    = '0;
        w    = wi;
        c    = ci;
        stop = 1'b0;
        n    = '0;
        for (int s = 0; s < 3; s++) begin
            if (!stop && c != 2'd0) begin
                b0     = w[0];
                b1     = w[1];
                r      = 8'd0;
                g      = '0;
                gn     = 2'd0;
                take   = 2'd1;
                wt     = 1'b0;
                plain  = 1'b0;
                triple = 1'b0;
                case (b0)
                    CH_COMMA: begin
                        g[0] = CH_SPACE; gn = 2'd1;
                    end
                    CH_LBRK: begin
                        g[0] = CH_LPAR; g[1] = CH_QUOTE; g[2] = CH_SPACE; gn = 2'd3;
                    end
                    CH_LBRACE: begin
                        g[0] = CH_LPAR; g[1] = CH_DQUOTE; g[2] = CH_SPACE; gn = 2'd3;
                    end
                    CH_RBRACE, CH_RBRK, CH_GT: begin
                        g[0] = CH_RPAR; gn = 2'd1;
                    end
                    CH_LT: begin
                        if (c < 2'd2) begin
                            if (!fin) wt = 1'b1;
                            else begin
                                g[0] = CH_LPAR; gn = 2'd1;
                            end
                        end else if (b1 != CH_MINUS) begin
                            g[0] = CH_LPAR; gn = 2'd1;
                        end else begin
                            triple = 1'b1;
                        end
                    end
                    CH_AMP, CH_SLASH, CH_BSLASH: begin
                        if (c < 2'd2) begin
                            if (!fin) wt = 1'b1;
                            else plain = 1'b1;
                        end else begin
                            if (b0 == CH_AMP) begin
                                if (b1 == CH_SLASH) r = CH_PLUS;
                                else if (b1 == CH_BAR || b1 == CH_AMP) r = CH_SEMI;
                            end else if (b0 == CH_SLASH) begin
                                if (b1 == CH_ONE) r = CH_SLASH;
                                else if (b1 == CH_TWO) r = CH_PCT;
                            end else begin
                                if (b1 == CH_ONE) r = CH_BSLASH;
                                else if (b1 == CH_TWO) r = CH_HASH;
                            end
                            if (r != 8'd0) begin
                                g[0] = r; gn = 2'd1; take = 2'd2;
                            end else begin
                                plain = 1'b1;
                            end
                        end
                    end
                    CH_MINUS, CH_EQ: begin
                        if (c < 2'd2) begin
                            if (!fin) wt = 1'b1;
                            else plain = 1'b1;
                        end else if (b0 == CH_MINUS && b1 == CH_MINUS) begin
                            triple = 1'b1;
                        end else if (b0 == CH_EQ && (b1 == CH_SLASH || b1 == CH_EQ)) begin
                            triple = 1'b1;
                        end else begin
                            plain = 1'b1;
                        end
                    end
                    default: plain = 1'b1;
                endcase

                if (triple) begin
                    if (c < 2'd3) begin
                        if (!fin) wt = 1'b1;
                        else plain = 1'b1;
                    end else if (b0 == CH_MINUS) begin
                        // a double dash swallows the byte after it
                        g[0] = (w[2] == CH_GT) ? CH_COLON : CH_BANG;
                        gn = 2'd1; take = 2'd3;
                    end else if (w[2] == CH_GT) begin
                        g[0] = (b0 == CH_LT) ? CH_EQ : CH_DOLLAR;
                        gn = 2'd1; take = 2'd3;
                    end else begin
                        plain = 1'b1;
                    end
                end

                if (plain) begin
                    g[0] = b0; gn = 2'd1;
                end

                if (wt) begin
                    stop = 1'b1;
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        if (k < int'(gn) && n < TOK_W'(MAX_TOK)) begin
                            d.tok[n] = g[k];
                            n = n + TOK_W'(1);
                        end
                    end
                    if (take == 2'd1) begin
                        w[0] = w[1]; w[1] = w[2];
                    end else if (take == 2'd2) begin
                        w[0] = w[2];
                    end
                    c = (take > c) ? 2'd0 : c - take;
                end
            end
        end
        d.ntok = n;
        d.rest = w[1:0];
        d.rcnt = c;
        return d;
    endfunction

    logic [1:0][7:0]  r_pend;
    logic [1:0]       r_pcnt;
    logic [LEN_W-1:0] r_len;
    logic [1:0][7:0]  n_pend;
    logic [1:0]       n_pcnt;
    logic [LEN_W-1:0] n_len;

    logic [2:0][7:0] win;
    t_dec            dec;
    logic            tl;

    always_comb begin
        win[0] = (r_pcnt == 2'd0) ? i_char_in : r_pend[0];
        win[1] = (r_pcnt == 2'd1) ? i_char_in : r_pend[1];
        win[2] = i_char_in;
        dec    = decode(win, r_pcnt + 2'd1, i_final_char);
    end

    assign n_len = (r_len <= LEN_W'(MAX_LEN)) ? r_len + LEN_W'(1) : r_len;
    assign tl    = n_len > LEN_W'(MAX_LEN - 3);

    assign o_accept = i_valid && !i_full;
    assign o_push   = o_accept && (dec.ntok != '0);

    always_comb begin
        o_rec      = '0;
        o_rec.tok  = dec.tok;
        o_rec.ntok = dec.ntok;
        o_rec.fin  = i_final_char;
        o_rec.tl   = tl;
    end

    always_comb begin
        n_pend = '0;
        n_pcnt = 2'd0;
        if (!i_final_char) begin
            n_pcnt = dec.rcnt;
            if (dec.rcnt > 2'd0) n_pend[0] = dec.rest[0];
            if (dec.rcnt > 2'd1) n_pend[1] = dec.rest[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_pcnt <= 2'd0;
            r_len  <= '0;
        end else if (o_accept) begin
            r_pend <= n_pend;
            r_pcnt <= n_pcnt;
            r_len  <= i_final_char ? '0 : n_len;
        end
    end

endmodule

// ===== rtl/ncc_queue.sv =====
// Small FIFO of decoded records between front and back end.
`timescale 1ns / 1ps

module ncc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ncc_pkg::t_rec i_rec,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output ncc_pkg::t_rec o_head
);
    import ncc_pkg::*;

    t_rec              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == QCNT_W'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            if (i_pop)  r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + QCNT_W'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - QCNT_W'(1);
        end
    end

endmodule

// ===== rtl/ncc_back.sv =====
// Back end: walks the queued characters, pads parens, drives the output register.
`timescale 1ns / 1ps

module ncc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  ncc_pkg::t_rec i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_char_out,
    output logic          o_run_last,
    output logic          o_stream_end,
    output logic          o_too_long
);
    import ncc_pkg::*;

    logic [TOK_W-1:0] r_tk;
    logic [1:0]       r_ph;
    logic             r_valid;
    logic [7:0]       r_char;
    logic             r_last;
    logic             r_end;
    logic             r_tl;

    logic [7:0] cur;
    logic       paren;
    logic [7:0] byte_out;
    logic       tok_done;
    logic       last_tok;
    logic       load;

    assign cur      = i_head.tok[r_tk];
    assign paren    = (cur == CH_LPAR) || (cur == CH_RPAR);
    // padded paren goes out as space, paren, space
    assign byte_out = (paren && r_ph != 2'd1) ? CH_SPACE : cur;
    assign tok_done = !paren || (r_ph == 2'd2);
    assign last_tok = r_tk == (i_head.ntok - TOK_W'(1));
    assign load     = !i_empty && (!r_valid || !i_stall);
    assign o_pop    = load && tok_done && last_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tk    <= '0;
            r_ph    <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (!r_valid || !i_stall) r_valid <= !i_empty;
            if (load) begin
                if (tok_done) begin
                    r_ph <= 2'd0;
                    r_tk <= last_tok ? '0 : r_tk + TOK_W'(1);
                end else begin
                    r_ph <= r_ph + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= byte_out;
            r_last <= tok_done && last_tok;
            r_end  <= tok_done && last_tok && i_head.fin;
            r_tl   <= i_head.tl;
        end
    end

    assign o_valid      = r_valid;
    assign o_char_out   = r_char;
    assign o_run_last   = r_last;
    assign o_stream_end = r_end;
    assign o_too_long   = r_tl;

endmodule

// ===== rtl/narsese_copula_canonicalizer_unit.sv =====
// Path: the queue registers each input record, then the output register holds each byte.
// Throughput: one input byte per cycle while the two-record queue has room; the output
// side moves one byte per cycle while i_stall is low, one transfer per output byte.
// Expansion per input byte is 0 to 8 output bytes (a padded paren is three).
// Reset: synchronous active-low; clears lookahead buffer, length count, queue and output valid.
`timescale 1ns / 1ps

module narsese_copula_canonicalizer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_final_char,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_char_out,
    output logic       o_run_last,
    output logic       o_stream_end,
    output logic       o_too_long
);
    import ncc_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_rec rec;
    t_rec head;

    assign o_stall = full;

    ncc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_char_in    (i_char_in),
        .i_final_char (i_final_char),
        .i_full       (full),
        .o_accept     (accept),
        .o_push       (push),
        .o_rec        (rec)
    );

    ncc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && accept),
        .i_rec   (rec),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    ncc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_char_out   (o_char_out),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end),
        .o_too_long   (o_too_long)
    );

endmodule

// ===== tb/canon_text_checker.sv =====
// Scoreboard for the copula canonicalizer: predicts the canonical byte stream and compares.
`timescale 1ns / 1ps

module canon_text_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_final_char,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_char_out,
    input  logic       i_run_last,
    input  logic       i_stream_end,
    input  logic       i_too_long,
    output int         o_fail_count,
    output int         o_open_bytes
);
    import ncc_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       stream_end;
        logic       too_long;
    } t_canon_byte;

    t_canon_byte expected_bytes [$];
    t_canon_byte run_bytes [$];

    logic [7:0]  held [2];
    int unsigned held_cnt;
    int unsigned stmt_len;
    int          fails;

    task automatic put_one(input logic [7:0] ch, input logic tl);
        t_canon_byte b;
        b = '{ch: ch, run_last: 1'b0, stream_end: 1'b0, too_long: tl};
        if (run_bytes.size() < 8) run_bytes.push_back(b);
    endtask

    task automatic put_padded(input logic [7:0] ch, input logic tl);
        if (ch == CH_LPAR || ch == CH_RPAR) begin
            put_one(CH_SPACE, tl);
            put_one(ch, tl);
            put_one(CH_SPACE, tl);
        end else begin
            put_one(ch, tl);
        end
    endtask

    // Expected output bytes for one input transfer; held lookahead kept across calls.
    task automatic canonicalize_byte(input logic [7:0] in_ch, input logic fin);
        logic [7:0]  w [3];
        logic [7:0]  b0;
        logic [7:0]  r;
        int unsigned c;
        int unsigned take;
        int unsigned k;
        logic        tl;
        logic        wait_more;
        logic        plain;
        logic        triple;

        c = held_cnt;
        for (k = 0; k < c; k++) w[k] = held[k];
        w[c] = in_ch;
        c++;
        if (stmt_len <= MAX_LEN) stmt_len++;
        tl = (stmt_len > MAX_LEN - 3);
        run_bytes.delete();

        while (c > 0) begin
            b0 = w[0];
            take = 1;
            wait_more = 1'b0;
            plain = 1'b0;
            triple = 1'b0;
            case (b0)
                CH_COMMA: put_padded(CH_SPACE, tl);
                CH_LBRK: begin
                    put_padded(CH_LPAR, tl);
                    put_padded(CH_QUOTE, tl);
                    put_padded(CH_SPACE, tl);
                end
                CH_LBRACE: begin
                    put_padded(CH_LPAR, tl);
                    put_padded(CH_DQUOTE, tl);
                    put_padded(CH_SPACE, tl);
                end
                CH_RBRACE, CH_RBRK, CH_GT: put_padded(CH_RPAR, tl);
                CH_LT: begin
                    if (c < 2) begin
                        if (!fin) wait_more = 1'b1;
                        else put_padded(CH_LPAR, tl);
                    end else if (w[1] != CH_MINUS) begin
                        put_padded(CH_LPAR, tl);
                    end else begin
                        triple = 1'b1;
                    end
                end
                CH_AMP, CH_SLASH, CH_BSLASH: begin
                    if (c < 2) begin
                        if (!fin) wait_more = 1'b1;
                        else plain = 1'b1;
                    end else begin
                        // 8'h00 marks "no two-byte copula here"
                        if (b0 == CH_AMP)
                            r = (w[1] == CH_SLASH) ? CH_PLUS :
                                (w[1] == CH_BAR || w[1] == CH_AMP) ? CH_SEMI : 8'h00;
                        else if (b0 == CH_SLASH)
                            r = (w[1] == CH_ONE) ? CH_SLASH :
                                (w[1] == CH_TWO) ? CH_PCT : 8'h00;
                        else
                            r = (w[1] == CH_ONE) ? CH_BSLASH :
                                (w[1] == CH_TWO) ? CH_HASH : 8'h00;
                        if (r != 8'h00) begin
                            put_padded(r, tl);
                            take = 2;
                        end else begin
                            plain = 1'b1;
                        end
                    end
                end
                CH_MINUS, CH_EQ: begin
                    if (c < 2) begin
                        if (!fin) wait_more = 1'b1;
                        else plain = 1'b1;
                    end else if (b0 == CH_MINUS && w[1] == CH_MINUS) begin
                        triple = 1'b1;
                    end else if (b0 == CH_EQ && (w[1] == CH_SLASH || w[1] == CH_EQ)) begin
                        triple = 1'b1;
                    end else begin
                        plain = 1'b1;
                    end
                end
                default: plain = 1'b1;
            endcase

            if (triple) begin
                if (c < 3) begin
                    if (!fin) wait_more = 1'b1;
                    else plain = 1'b1;
                end else if (b0 == CH_MINUS) begin
                    // "--x" with x other than '>' swallows x
                    put_padded((w[2] == CH_GT) ? CH_COLON : CH_BANG, tl);
                    take = 3;
                end else if (w[2] == CH_GT) begin
                    put_padded((b0 == CH_LT) ? CH_EQ : CH_DOLLAR, tl);
                    take = 3;
                end else begin
                    plain = 1'b1;
                end
            end

            if (wait_more) break;
            if (plain) put_padded(b0, tl);
            if (take > c) take = c;
            for (k = 0; k + take < c; k++) w[k] = w[k + take];
            c -= take;
        end

        if (fin) begin
            held_cnt = 0;
            held[0] = 8'h00;
            held[1] = 8'h00;
            stmt_len = 0;
        end else begin
            held_cnt = c;
            for (k = 0; k < 2; k++) held[k] = (k < c) ? w[k] : 8'h00;
        end

        if (run_bytes.size() > 0) begin
            run_bytes[run_bytes.size() - 1].run_last = 1'b1;
            run_bytes[run_bytes.size() - 1].stream_end = fin;
        end
        for (k = 0; k < run_bytes.size(); k++) expected_bytes.push_back(run_bytes[k]);
    endtask

    initial begin
        held[0] = 8'h00;
        held[1] = 8'h00;
        held_cnt = 0;
        stmt_len = 0;
        fails = 0;
        o_fail_count = 0;
        o_open_bytes = 0;
    end

    always @(posedge i_clk) begin
        t_canon_byte want;
        if (!i_rst_n) begin
            held[0] = 8'h00;
            held[1] = 8'h00;
            held_cnt = 0;
            stmt_len = 0;
            expected_bytes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected output transfer: char_out %h", i_char_out);
                    fails++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_char_out !== want.ch) begin
                        $error("char_out: expected %h, got %h", want.ch, i_char_out);
                        fails++;
                    end
                    if (i_run_last !== want.run_last) begin
                        $error("run_last: expected %b, got %b", want.run_last, i_run_last);
                        fails++;
                    end
                    if (i_stream_end !== want.stream_end) begin
                        $error("stream_end: expected %b, got %b", want.stream_end,
                               i_stream_end);
                        fails++;
                    end
                    if (i_too_long !== want.too_long) begin
                        $error("too_long: expected %b, got %b", want.too_long, i_too_long);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) canonicalize_byte(i_char_in, i_final_char);
        end
        o_fail_count <= fails;
        o_open_bytes <= expected_bytes.size();
    end

endmodule

// ===== tb/tb.sv =====
// Top of the canonicalizer testbench: clock, reset, statement stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_char_in = 8'h00;
    logic       i_final_char = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_char_out;
    logic       o_run_last;
    logic       o_stream_end;
    logic       o_too_long;

    int         fail_count;
    int         open_bytes;
    int         bytes_sent = 0;
    logic       calm = 1'b0;
    logic [7:0] stmt_bytes [$];

    narsese_copula_canonicalizer_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_char_in    (i_char_in),
        .i_final_char (i_final_char),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_char_out   (o_char_out),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end),
        .o_too_long   (o_too_long)
    );

    canon_text_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_char_in    (i_char_in),
        .i_final_char (i_final_char),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_char_out   (o_char_out),
        .i_run_last   (o_run_last),
        .i_stream_end (o_stream_end),
        .i_too_long   (o_too_long),
        .o_fail_count (fail_count),
        .o_open_bytes (open_bytes)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Output side backpressure.
    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < 13);
    end

    // Returns at the edge where the byte transfer happened; valid stays up for the next one.
    task automatic send_byte(input logic [7:0] ch, input logic fin);
        while (!calm && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_in <= ch;
        i_final_char <= fin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) send_byte(s[k], k == s.len() - 1);
    endtask

    task automatic push_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) stmt_bytes.push_back(s[k]);
    endtask

    // Mostly copula and bracket pieces, some lone prefixes, letters and raw noise.
    task automatic add_fragment();
        case ($urandom_range(0, 30))
            0:  push_text("-->");
            1:  push_text("<->");
            2:  push_text("==>");
            3:  push_text("=/>");
            4:  push_text("&/");
            5:  push_text("&&");
            6:  push_text("&|");
            7:  push_text("/1");
            8:  push_text("/2");
            9:  push_text("\\1");
            10: push_text("\\2");
            11: push_text("<");
            12: push_text(">");
            13: push_text("[");
            14: push_text("]");
            15: push_text("{");
            16: push_text("}");
            17: push_text(",");
            18: push_text("--");
            19: push_text("-");
            20: push_text("=");
            21: push_text("&");
            22: push_text("/");
            23: push_text("\\");
            24: push_text("<-");
            25, 26, 27: stmt_bytes.push_back(8'($urandom_range(8'h61, 8'h7a)));
            default: stmt_bytes.push_back(8'($urandom_range(255)));
        endcase
    endtask

    task automatic send_statement(input int nbytes);
        int k;
        stmt_bytes.delete();
        while (stmt_bytes.size() < nbytes) add_fragment();
        for (k = 0; k < stmt_bytes.size(); k++)
            send_byte(stmt_bytes[k], k == stmt_bytes.size() - 1);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: copulas, brackets, bang with swallowed byte, flushed lookahead,
        // trailing '<', null and all-ones bytes.
        send_text("<a-->[b]>");
        send_text("--x=/<");
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte("&", 1'b1);
        send_text("/1\\2&|");

        while (bytes_sent < 120) send_statement($urandom_range(1, 12));
        // Long enough to raise too_long and saturate the length count.
        send_statement(262);
        calm = 1'b1;
        while (bytes_sent < 440) send_statement($urandom_range(1, 12));
        calm = 1'b0;
        while (bytes_sent < 465) send_statement($urandom_range(1, 12));

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (open_bytes != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #500000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
